@@ rtl/core/dcfs_pkg.sv @@
// Package of the dual-channel frequency supervisor.
// Holds the beat types, register codes, sizes and controller types.
// No dependencies.
`default_nettype none

package dcfs_pkg;

  localparam int unsigned FREQ_BITS        = 24;
  localparam int unsigned CNT_BITS         = $clog2(FREQ_BITS);
  localparam int unsigned CAP_FIELD_BITS   = 16;
  localparam int unsigned ADDR_BITS        = 3;
  localparam int unsigned DATA_BITS        = 32;
  localparam int unsigned CHANNELS_DEF     = 2;
  localparam int unsigned CAPTURE_BITS_DEF = 16;

  localparam logic [FREQ_BITS-1:0] TICK_RATE_RESET     = 24'd1000000;
  localparam logic [FREQ_BITS-1:0] EXPECTED_FREQ_RESET = 24'd10000;

  localparam logic REG_TICK_RATE     = 1'b0;
  localparam logic REG_EXPECTED_FREQ = 1'b1;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic                      channel;
    logic [CAP_FIELD_BITS-1:0] capture_value;
  } in_beat_t;

  typedef struct packed {
    logic                 freq_valid;
    logic                 freq_channel;
    logic [FREQ_BITS-1:0] frequency;
    logic                 laser_off;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/dcfs_regs.sv @@
// Configuration registers of the frequency supervisor behind an APB-style port.
// Depends on dcfs_pkg.
`default_nettype none

module dcfs_regs
  import dcfs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output logic      [FREQ_BITS-1:0] tick_rate_o,
  output logic      [FREQ_BITS-1:0] expected_freq_o
);

  logic [FREQ_BITS-1:0] tick_rate_q;
  logic [FREQ_BITS-1:0] expected_freq_q;
  logic                 reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q     <= TICK_RATE_RESET;
      expected_freq_q <= EXPECTED_FREQ_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TICK_RATE:     tick_rate_q     <= pwdata[FREQ_BITS-1:0];
        REG_EXPECTED_FREQ: expected_freq_q <= pwdata[FREQ_BITS-1:0];
        default:           tick_rate_q     <= tick_rate_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TICK_RATE:     prdata = DATA_BITS'(tick_rate_q);
      REG_EXPECTED_FREQ: prdata = DATA_BITS'(expected_freq_q);
      default:           prdata = '0;
    endcase
  end

  assign tick_rate_o     = tick_rate_q;
  assign expected_freq_o = expected_freq_q;

endmodule

`default_nettype wire

@@ rtl/core/dcfs_ctrl.sv @@
// Controller state machine of the frequency supervisor.
// Sequences accept, division and write-back; depends on dcfs_pkg.
`default_nettype none

module dcfs_ctrl
  import dcfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.needs_div) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/dcfs_datapath.sv @@
// Datapath of the frequency supervisor: channel state, restoring divider
// and output register. Driven by dcfs_ctrl; depends on dcfs_pkg.
`default_nettype none

module dcfs_datapath
  import dcfs_pkg::*;
#(
  parameter int unsigned CHANNELS     = CHANNELS_DEF,
  parameter int unsigned CAPTURE_BITS = CAPTURE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire in_beat_t             in_data_i,
  input  wire logic [FREQ_BITS-1:0] tick_rate_i,
  input  wire logic [FREQ_BITS-1:0] expected_freq_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_status_t                status_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_beat_t                 out_data_o
);

  localparam int unsigned PW  = CAPTURE_BITS + 1;
  localparam int unsigned CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                    op_q;
  logic                    chan_q;
  logic [CAPTURE_BITS-1:0] cap_q;
  logic                    pending_q [CHANNELS];
  logic [CAPTURE_BITS-1:0] first_q   [CHANNELS];
  logic [FREQ_BITS-1:0]    meas_q    [CHANNELS];
  logic                    alarm_q;
  logic [PW-1:0]           rem_q;
  logic [FREQ_BITS-1:0]    quo_q;
  logic [PW-1:0]           dvs_q;
  logic [CNT_BITS-1:0]     cnt_q;
  out_beat_t               out_q;
  out_beat_t               out_d;
  logic                    out_valid_q;

  logic [CIW-1:0]          in_idx;
  logic                    in_ch_ok;
  logic [CAPTURE_BITS-1:0] cap_in;
  logic [CAPTURE_BITS-1:0] diff_in;
  logic [PW-1:0]           period_in;
  logic [PW:0]             trial;
  logic [PW:0]             trial_sub;
  logic                    trial_ge;
  logic [CIW-1:0]          idx_q;
  logic                    ch_ok_q;
  logic                    healthy;

  assign in_idx    = CIW'(in_data_i.channel);
  assign in_ch_ok  = (CHANNELS > 1) || (in_data_i.channel == 1'b0);
  assign cap_in    = CAPTURE_BITS'(in_data_i.capture_value);
  assign diff_in   = cap_in - first_q[in_idx];
  assign period_in = (diff_in == '0) ? {1'b1, {CAPTURE_BITS{1'b0}}} : {1'b0, diff_in};

  assign status_o.needs_div = (in_data_i.opcode == OP_CAPTURE) && in_ch_ok &&
                              pending_q[in_idx];
  assign status_o.div_last  = (cnt_q == CNT_BITS'(FREQ_BITS - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign trial     = {rem_q, quo_q[FREQ_BITS-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign trial_ge  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.opcode;
      chan_q <= in_data_i.channel;
      cap_q  <= cap_in;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= tick_rate_i;
      dvs_q <= period_in;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[PW-1:0] : trial[PW-1:0];
      quo_q <= {quo_q[FREQ_BITS-2:0], trial_ge};
      cnt_q <= cnt_q + CNT_BITS'(1);
    end
  end

  assign idx_q   = CIW'(chan_q);
  assign ch_ok_q = (CHANNELS > 1) || (chan_q == 1'b0);

  always_comb begin
    healthy = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (meas_q[i] != expected_freq_i) begin
        healthy = 1'b0;
      end
    end
  end

  always_comb begin
    out_d = '0;
    if (op_q == OP_TICK) begin
      out_d.laser_off = !healthy && !alarm_q;
    end else if (ch_ok_q && pending_q[idx_q]) begin
      out_d.freq_valid   = 1'b1;
      out_d.freq_channel = chan_q;
      out_d.frequency    = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pending_q[i] <= 1'b0;
        meas_q[i]    <= '0;
      end
    end else if (cmd_i.commit) begin
      if (op_q == OP_TICK) begin
        if (healthy) begin
          alarm_q <= 1'b0;
          for (int i = 0; i < CHANNELS; i++) begin
            meas_q[i] <= '0;
          end
        end else begin
          alarm_q <= 1'b1;
        end
      end else if (ch_ok_q) begin
        if (!pending_q[idx_q]) begin
          pending_q[idx_q] <= 1'b1;
        end else begin
          pending_q[idx_q] <= 1'b0;
          meas_q[idx_q]    <= quo_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (op_q == OP_CAPTURE) && ch_ok_q && !pending_q[idx_q]) begin
      first_q[idx_q] <= cap_q;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/dual_channel_frequency_supervisor_core.sv @@
// Top level of the dual-channel frequency supervisor.
// Instantiates dcfs_regs, dcfs_ctrl and dcfs_datapath; depends on dcfs_pkg.
//
// Each beat is a capture event or a supervision tick and yields exactly one
// result beat. The block works on one beat at a time: a tick, a first capture
// or an ignored channel goes from acceptance to the result state, and a second
// capture passes through the division state first, as the shared restoring
// divider produces one quotient bit of the 24-bit frequency per cycle. The
// result state loads the output register once it is free. The next beat is
// accepted from the cycle after the result is loaded. A finished result waits
// in the output register, and the next beat is accepted meanwhile. Both registers
// reset to their defaults at once; there is no clearing pass after reset.
`default_nettype none

module dual_channel_frequency_supervisor_core
  import dcfs_pkg::*;
#(
  parameter int unsigned CHANNELS     = CHANNELS_DEF,
  parameter int unsigned CAPTURE_BITS = CAPTURE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_beat_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_beat_t                 out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready
);

  logic [FREQ_BITS-1:0] tick_rate;
  logic [FREQ_BITS-1:0] expected_freq;
  dp_cmd_t              cmd;
  dp_status_t           status;

  dcfs_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .tick_rate_o     (tick_rate),
    .expected_freq_o (expected_freq)
  );

  dcfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dcfs_datapath #(
    .CHANNELS     (CHANNELS),
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_data_i       (in_data_i),
    .tick_rate_i     (tick_rate),
    .expected_freq_i (expected_freq),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_o      (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/dcfs_checker.sv @@
// Port-level checker of the frequency supervisor, bound to the top level.
// Depends on dcfs_pkg and dual_channel_frequency_supervisor_core.
`default_nettype none

module dcfs_checker
  import dcfs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_beat_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result beat changed or vanished.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.freq_valid && out_data_o.laser_off))
    else $error("Result beat carries both a frequency and a laser-off command.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.freq_valid |->
      out_data_o.frequency == '0 && out_data_o.freq_channel == 1'b0)
    else $error("Result beat without a frequency has nonzero frequency fields.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input beat accepted while the previous one is still in work.");

endmodule

bind dual_channel_frequency_supervisor_core dcfs_checker u_dcfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for dual_channel_frequency_supervisor_core.
// Predicts every result beat from captures, ticks and the APB registers, and
// varies idling and back-pressure. Depends on dcfs_pkg and the core RTL only.
module tb_top;
  import dcfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_BEATS = 160;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_data   = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data_o;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [DATA_BITS-1:0] pwdata    = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  dual_channel_frequency_supervisor_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  in_beat_t    beat_q[$];
  out_beat_t   result_q[$];
  int unsigned fail_count    = 0;
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_tag      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  logic [FREQ_BITS-1:0]      cfg_tick_rate     = TICK_RATE_RESET;
  logic [FREQ_BITS-1:0]      cfg_expected_freq = EXPECTED_FREQ_RESET;
  logic                      pair_open[CHANNELS_DEF];
  logic [CAP_FIELD_BITS-1:0] first_cap[CHANNELS_DEF];
  logic [FREQ_BITS-1:0]      meas_freq[CHANNELS_DEF];
  logic                      alarm_issued;

  logic                      gen_open[CHANNELS_DEF];
  logic [CAP_FIELD_BITS-1:0] gen_first[CHANNELS_DEF];

  initial begin
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      pair_open[i] = 1'b0;
      first_cap[i] = '0;
      meas_freq[i] = '0;
      gen_open[i]  = 1'b0;
      gen_first[i] = '0;
    end
    alarm_issued = 1'b0;
  end

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic out_beat_t supervise_beat(input in_beat_t beat);
    out_beat_t                 res;
    logic [CAP_FIELD_BITS-1:0] diff;
    logic [CAP_FIELD_BITS:0]   span;
    logic                      healthy;
    int unsigned               ch;
    res = '0;
    ch  = beat.channel;
    if (beat.opcode == OP_TICK) begin
      healthy = 1'b1;
      for (int i = 0; i < CHANNELS_DEF; i++)
        if (meas_freq[i] != cfg_expected_freq) healthy = 1'b0;
      if (healthy) begin
        for (int i = 0; i < CHANNELS_DEF; i++) meas_freq[i] = '0;
        alarm_issued = 1'b0;
      end else if (!alarm_issued) begin
        alarm_issued  = 1'b1;
        res.laser_off = 1'b1;
      end
    end else if (!pair_open[ch]) begin
      first_cap[ch] = beat.capture_value;
      pair_open[ch] = 1'b1;
    end else begin
      // Equal captures stand for one full counter wrap.
      diff = beat.capture_value - first_cap[ch];
      span = (diff == '0) ? {1'b1, {CAP_FIELD_BITS{1'b0}}} : {1'b0, diff};
      meas_freq[ch]    = cfg_tick_rate / span;
      pair_open[ch]    = 1'b0;
      res.freq_valid   = 1'b1;
      res.freq_channel = beat.channel;
      res.frequency    = meas_freq[ch];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    logic     offer;
    in_beat_t next_beat;
    offer     = in_valid;
    next_beat = in_data;
    if (!rst_ni) begin
      offer = 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        result_q.push_back(supervise_beat(in_data));
        offer = 1'b0;
      end
      if (!offer && beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_beat = beat_q.pop_front();
        offer     = 1'b1;
      end
    end
    in_valid <= offer;
    in_data  <= next_beat;
  end

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    logic      hold;
    if (!rst_ni) begin
      hold = 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (result_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = result_q.pop_front();
          check_field("freq_valid", out_data_o.freq_valid, want.freq_valid);
          check_field("freq_channel", out_data_o.freq_channel, want.freq_channel);
          check_field("frequency", out_data_o.frequency, want.frequency);
          check_field("laser_off", out_data_o.laser_off, want.laser_off);
        end
      end
      if (hold_left != 0) begin
        hold = 1'b1;
      end else begin
        hold = ($urandom_range(0, 99) < stall_pct);
      end
    end
    out_stall <= hold;
  end

  task automatic cfg_read(input logic sel, input logic [FREQ_BITS-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[FREQ_BITS-1:0] !== want)
      flag_mismatch($sformatf("register %0d reads %0h, want %0h", sel, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_reg(input logic sel, input logic [FREQ_BITS-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {8'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_TICK_RATE) cfg_tick_rate = value;
    else cfg_expected_freq = value;
    cfg_read(sel, value);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 87; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 87; end
      default: begin send_idle_pct = 10; stall_pct = 10; end
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (beat_q.size() != 0 || in_valid || result_q.size() != 0);
  endtask

  function automatic in_beat_t beat_of(input logic op, input logic ch,
                                       input logic [CAP_FIELD_BITS-1:0] value);
    in_beat_t b;
    b.opcode        = op;
    b.channel       = ch;
    b.capture_value = value;
    return b;
  endfunction

  // Mostly well-formed pairs at the healthy period, with ticks, odd spans and
  // random captures mixed in.
  task automatic queue_random(input int unsigned count, input logic [CAP_FIELD_BITS:0] good);
    in_beat_t                  b;
    int unsigned               ch;
    logic [CAP_FIELD_BITS-1:0] step;
    repeat (count) begin
      b = beat_of(OP_CAPTURE, 1'($urandom_range(0, 1)), 16'($urandom()));
      if ($urandom_range(0, 99) < 15) begin
        b.opcode = OP_TICK;
      end else begin
        ch = b.channel;
        if (gen_open[ch]) begin
          case ($urandom_range(0, 9))
            0: step = '0;
            1: step = '1;
            2: step = 16'd1;
            3: step = 16'($urandom());
            default: step = good[CAP_FIELD_BITS-1:0];
          endcase
          b.capture_value = gen_first[ch] + step;
        end else begin
          gen_first[ch] = b.capture_value;
        end
        gen_open[ch] = !gen_open[ch];
      end
      beat_q.push_back(b);
    end
  endtask

  task automatic run_phase(input logic [FREQ_BITS-1:0] rate, input logic [CAP_FIELD_BITS:0] good,
                           input logic [FREQ_BITS-1:0] target, input int unsigned mode);
    program_reg(REG_TICK_RATE, rate);
    program_reg(REG_EXPECTED_FREQ, target);
    @(negedge clk_i);
    set_idling(mode);
    queue_random(PHASE_BEATS, good);
    wait_drained();
  endtask

  initial begin
    logic [FREQ_BITS-1:0]    rate;
    logic [CAP_FIELD_BITS:0] good;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_read(REG_TICK_RATE, TICK_RATE_RESET);
    cfg_read(REG_EXPECTED_FREQ, EXPECTED_FREQ_RESET);

    @(negedge clk_i);
    set_idling(0);
    beat_q.push_back(beat_of(OP_TICK, 1'b0, 16'h0000));
    beat_q.push_back(beat_of(OP_TICK, 1'b1, 16'hFFFF));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b0, 16'hFFC0));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b0, 16'h0024));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b1, 16'h1000));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b1, 16'h1064));
    beat_q.push_back(beat_of(OP_TICK, 1'b0, 16'h1234));
    beat_q.push_back(beat_of(OP_TICK, 1'b1, 16'h0000));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b0, 16'hFFFF));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b0, 16'hFFFF));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b1, 16'h0000));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b1, 16'hFFFF));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b1, 16'h5555));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b1, 16'h5556));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b0, 16'hAAAA));
    beat_q.push_back(beat_of(OP_CAPTURE, 1'b0, 16'hAB0E));
    beat_q.push_back(beat_of(OP_TICK, 1'b0, 16'hFFFF));
    wait_drained();

    run_phase(24'hFFFFFF, 17'd1, 24'hFFFFFF, 0);
    run_phase(24'd0, 17'd100, 24'd0, 1);
    run_phase(24'd1, 17'd1, 24'd1, 2);
    run_phase(TICK_RATE_RESET, 17'd100, EXPECTED_FREQ_RESET, 3);
    for (int p = 4; p < 12; p++) begin
      rate = FREQ_BITS'($urandom_range(1, 24'hFFFFFF));
      good = ($urandom_range(0, 3) == 0) ? (CAP_FIELD_BITS + 1)'($urandom_range(1, 65536))
                                         : (CAP_FIELD_BITS + 1)'($urandom_range(1, 2000));
      run_phase(rate, good, rate / good, p % 4);
    end

    // The receiver holds off while the sender keeps offering beats.
    @(negedge clk_i);
    set_idling(0);
    queue_random(60, 17'd100);
    hold_tag++;
    wait_drained();

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
